@@ rtl/core/cmva_pkg.sv @@
// ----------------------------------------------------------------------------
// Centered modular vector add: shared definitions
// Widths, stage counts and the payload type that travels through the
// remainder pipeline.
// ----------------------------------------------------------------------------
package cmva_pkg;

  // Result width; the addends and the modulus are one bit narrower.
  localparam int unsigned DataWidth = 64;
  localparam int unsigned AddW      = DataWidth - 1;
  localparam int unsigned QW        = DataWidth - 1;

  // One remainder bit is resolved per stage, one stage per bit of the magnitude.
  localparam int unsigned RemStages = DataWidth;

  // Input beat: two addends packed, padded up to whole bytes.
  localparam int unsigned InDataW   = ((2 * AddW + 7) / 8) * 8;

  // Sign and magnitude of the sum, carried alongside the partial remainder.
  typedef struct packed {
    logic                 neg;
    logic [DataWidth-1:0] mag;
  } cmva_item_t;

endpackage

@@ rtl/core/cmva_rem_pipe.sv @@
// ----------------------------------------------------------------------------
// Centered modular vector add: remainder pipeline
// Restoring remainder of an unsigned magnitude by the modulus, one bit of the
// magnitude per register stage, most significant bit first.
// ----------------------------------------------------------------------------
module cmva_rem_pipe (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  cmva_pkg::cmva_item_t        item_i,
  input  logic [cmva_pkg::QW-1:0]     mod_i,
  output logic                        valid_o,
  output cmva_pkg::cmva_item_t        item_o,
  output logic [cmva_pkg::QW-1:0]     rem_o
);
  import cmva_pkg::*;

  // Registered outputs of each stage.
  logic [RemStages-1:0] stg_v_q;
  cmva_item_t           stg_item_q [RemStages];
  logic [QW-1:0]        stg_rem_q  [RemStages];

  for (genvar i = 0; i < RemStages; i++) begin : g_stage
    logic          v_in;
    cmva_item_t    item_in;
    logic [QW-1:0] rem_in;
    logic [QW:0]   trial;
    logic [QW+1:0] diff;

    // Stage inputs come from the port for the first stage.
    if (i == 0) begin : g_first
      assign v_in    = valid_i;
      assign item_in = item_i;
      assign rem_in  = '0;
    end else begin : g_next
      assign v_in    = stg_v_q[i-1];
      assign item_in = stg_item_q[i-1];
      assign rem_in  = stg_rem_q[i-1];
    end

    // Shift in the next magnitude bit and subtract the modulus when it fits.
    assign trial = {rem_in, item_in.mag[DataWidth-1-i]};
    assign diff  = {1'b0, trial} - {2'b00, mod_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stg_v_q[i] <= 1'b0;
      end else if (en_i) begin
        stg_v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_item_q[i] <= item_in;
        stg_rem_q[i]  <= diff[QW+1] ? trial[QW-1:0] : diff[QW-1:0];
      end
    end
  end

  assign valid_o = stg_v_q[RemStages-1];
  assign item_o  = stg_item_q[RemStages-1];
  assign rem_o   = stg_rem_q[RemStages-1];

  // The final partial remainder is always below a nonzero modulus.
  a_rem_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (mod_i != '0) |-> rem_o < mod_i)
    else $error("remainder not below modulus");

  // A stalled last stage keeps its item.
  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !en_i |=> valid_o)
    else $error("stalled remainder beat dropped");

endmodule

@@ rtl/core/centered_modular_vector_add_top.sv @@
// ----------------------------------------------------------------------------
// Centered modular vector add: top level
// Adds two signed elements per beat and optionally reduces the sum into the
// centered residue range of the configured modulus.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle while the pipeline is not stalled and
// returns one result beat for each input beat, in order. Between input and
// output lie the input, sum and magnitude registers, the remainder pipeline,
// which resolves one bit of the 64-bit sum magnitude per stage, and the
// sign-restore and output registers. A held output stalls the whole pipeline,
// and with it the input, as soon as the sign-restore stage in front of the output
// register holds a beat; while that stage is empty the pipeline keeps moving.
// Write the modulus only while no beat is in flight; zero returns the plain sum.
module centered_modular_vector_add_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cmva_pkg::QW-1:0]         cfg_wdata_i,   // modulus_value
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [cmva_pkg::InDataW-1:0]    s_axis_tdata,  // addend_a, addend_b, zero pad
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [cmva_pkg::DataWidth-1:0]  m_axis_tdata   // sum_out
);
  import cmva_pkg::*;

  // Modulus and its centered bounds, kept as registers beside the modulus.
  logic [QW-1:0]               mod_q;
  logic signed [DataWidth-1:0] hi_q, lo_q;
  logic [QW-2:0]               half_w;

  assign half_w = cfg_wdata_i[QW-1:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= '0;
      hi_q  <= '0;
      lo_q  <= '0;
    end else if (cfg_we_i) begin
      mod_q <= cfg_wdata_i;
      hi_q  <= $signed({2'b00, half_w}) - $signed({{(DataWidth-1){1'b0}}, ~cfg_wdata_i[0]});
      lo_q  <= -$signed({2'b00, half_w});
    end
  end

  // Global advance: move when the output can load or the last stage is empty.
  logic en;
  logic out_free;
  logic c_v_q;
  logic m_valid_q;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign en            = out_free || !c_v_q;
  assign s_axis_tready = en;

  // Stage 1: input register.
  logic            v1_q;
  logic [AddW-1:0] a_q, b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= s_axis_tdata[AddW-1:0];
      b_q <= s_axis_tdata[2*AddW-1:AddW];
    end
  end

  // Stage 2: sign-extended sum, which cannot overflow.
  logic                 v2_q;
  logic [DataWidth-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= {a_q[AddW-1], a_q} + {b_q[AddW-1], b_q};
    end
  end

  // Stage 3: split into sign and magnitude.
  logic       v3_q;
  cmva_item_t item3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      item3_q.neg <= sum_q[DataWidth-1];
      item3_q.mag <= sum_q[DataWidth-1] ? -sum_q : sum_q;
    end
  end

  // Remainder pipeline.
  logic          p_v;
  cmva_item_t    p_item;
  logic [QW-1:0] p_rem;

  cmva_rem_pipe u_rem_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .item_i  (item3_q),
    .mod_i   (mod_q),
    .valid_o (p_v),
    .item_o  (p_item),
    .rem_o   (p_rem)
  );

  // Restore the sign of the remainder (truncating remainder) and of the sum.
  logic signed [DataWidth-1:0] res_q, plain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en) begin
      c_v_q <= p_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q   <= p_item.neg ? -$signed({1'b0, p_rem}) : $signed({1'b0, p_rem});
      plain_q <= p_item.neg ? -$signed(p_item.mag) : $signed(p_item.mag);
    end
  end

  // Output register: fold the residue into the centered range, or pass the plain sum when the modulus is zero.
  logic signed [DataWidth-1:0] q_ext;
  logic signed [DataWidth-1:0] out_d;
  logic [DataWidth-1:0]        m_data_q;

  assign q_ext = $signed({1'b0, mod_q});

  always_comb begin
    if (mod_q == '0) begin
      out_d = plain_q;
    end else if (res_q > hi_q) begin
      out_d = res_q - q_ext;
    end else if (res_q < lo_q) begin
      out_d = res_q + q_ext;
    end else begin
      out_d = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_free) begin
      m_valid_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      m_data_q <= out_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Input is refused only behind a held result beat.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input refused without a held output beat");

  // With reduction on, every result lies in the centered range.
  a_centered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (mod_q != '0) |->
      ($signed(m_axis_tdata) <= hi_q) && ($signed(m_axis_tdata) >= lo_q))
    else $error("result outside centered range");

  // A sign-restore beat that cannot advance stays put.
  a_restore_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_v_q && !en |=> c_v_q)
    else $error("stalled beat dropped before output");

endmodule
